[src/lztd_pkg.sv]
// Package for the LZ77 token stream decoder.
// Holds the request types, the controller/datapath command and status
// structs, the token layout constants and the FSM state type. No dependencies.
package lztd_pkg;

  typedef struct packed {
    logic       start_of_stream;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        last_of_run;
    logic        bad_reference;
  } out_item_t;

  // what the byte at the input would cause if accepted now
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_LIT,
    KIND_BAD,
    KIND_COPY
  } in_kind_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_COPY
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic issue_rd;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    in_kind_t kind;
    logic     remain_nz;
    logic     pack_room;
    logic     pack_full;
    logic     pack_nz;
    logic     rd_pending;
    logic     out_free;
  } dp_status_t;

  localparam logic [7:0]  TOKEN_OPEN   = 8'hFF;
  localparam logic [7:0]  BIT_ONE      = 8'h31;
  localparam logic [4:0]  OFFSET_LAST  = 5'd15;
  localparam logic [4:0]  LENGTH_FIRST = 5'd17;
  localparam logic [4:0]  LENGTH_LAST  = 5'd24;
  localparam logic [4:0]  TOKEN_LAST   = 5'd25;
  localparam logic [8:0]  MIN_MATCH    = 9'd3;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

endpackage

[src/lztd_ctrl.sv]
// Controller FSM for the LZ77 token stream decoder.
// Sequences input acceptance and copy runs; depends on lztd_pkg.
module lztd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  lztd_pkg::dp_status_t status,
  output lztd_pkg::ctrl_cmd_t  cmd,
  output logic                in_stall
);
  import lztd_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.accept   = 1'b0;
    cmd.issue_rd = 1'b0;
    cmd.flush    = 1'b0;
    in_stall     = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall   = !status.out_free;
        cmd.accept = in_valid && status.out_free;
        if (cmd.accept && status.kind == KIND_COPY) begin
          state_nxt = ST_COPY;
        end
      end
      ST_COPY: begin
        cmd.issue_rd = status.remain_nz && status.pack_room;
        cmd.flush    = status.out_free &&
                       (status.pack_full ||
                        (status.pack_nz && !status.remain_nz && !status.rd_pending));
        if (cmd.flush && !status.remain_nz) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[src/lztd_datapath.sv]
// Datapath of the LZ77 token stream decoder: token parser, history memory,
// copy read pipeline, result packer and output register. Depends on lztd_pkg.
module lztd_datapath #(
  parameter int HISTORY_DEPTH    = 32768,
  parameter int BYTES_PER_RESULT = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lztd_pkg::in_item_t   in_data,
  input  lztd_pkg::ctrl_cmd_t  cmd,
  output lztd_pkg::dp_status_t status,
  input  logic                 out_stall,
  output logic                 out_valid,
  output lztd_pkg::out_item_t  out_data
);
  import lztd_pkg::*;

  localparam int AW     = $clog2(HISTORY_DEPTH);
  localparam int CW     = $clog2(BYTES_PER_RESULT + 1);
  localparam int PW     = 8 * BYTES_PER_RESULT;
  localparam logic [16:0] DEPTH_W = 17'(HISTORY_DEPTH);
  localparam logic [CW:0] BPR_W   = (CW + 1)'(BYTES_PER_RESULT);

  logic [7:0] mem [HISTORY_DEPTH];

  logic [4:0]    phase_r;
  logic [14:0]   off_r;
  logic [7:0]    len_r;
  logic [15:0]   count_r;
  logic [15:0]   rpos_r;
  logic [8:0]    remain_r;
  logic          rd_pending_r;
  logic          rd_zero_r;
  logic [7:0]    rd_data_r;
  logic [CW-1:0] pack_cnt_r;
  logic [PW-1:0] pack_data_r;
  logic          out_valid_r;
  out_item_t     out_r;

  logic [4:0]    phase_nxt;
  logic [14:0]   off_nxt;
  logic [7:0]    len_nxt;
  logic [15:0]   eff_count;
  logic [4:0]    eff_phase;
  logic          bit_one;
  in_kind_t      kind;
  logic          out_free;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic          rpos_in_range;
  logic [15:0]   wr_pos;
  logic [7:0]    land_byte;
  logic [PW-1:0] pack_ins;

  // parse of the byte at the input; committed only on accept
  always_comb begin
    eff_phase = in_data.start_of_stream ? 5'd0 : phase_r;
    eff_count = in_data.start_of_stream ? 16'd0 : count_r;
    bit_one   = (in_data.in_byte == BIT_ONE);
    phase_nxt = phase_r;
    off_nxt   = off_r;
    len_nxt   = len_r;
    kind      = KIND_NONE;
    if (eff_phase == 5'd0) begin
      if (in_data.in_byte == TOKEN_OPEN) begin
        phase_nxt = 5'd1;
        off_nxt   = 15'd0;
        len_nxt   = 8'd0;
      end else begin
        phase_nxt = 5'd0;
        kind      = KIND_LIT;
      end
    end else begin
      if (eff_phase <= OFFSET_LAST) begin
        off_nxt = {off_r[13:0], bit_one};
      end else if (eff_phase >= LENGTH_FIRST && eff_phase <= LENGTH_LAST) begin
        len_nxt = {len_r[6:0], bit_one};
      end
      if (eff_phase < TOKEN_LAST) begin
        phase_nxt = eff_phase + 5'd1;
      end else begin
        phase_nxt = 5'd0;
        kind      = ({1'b0, off_r} >= eff_count) ? KIND_BAD : KIND_COPY;
      end
    end
  end

  assign out_free      = !out_valid_r || !out_stall;
  assign rpos_in_range = {1'b0, rpos_r} < DEPTH_W;
  assign land_byte     = rd_zero_r ? 8'd0 : rd_data_r;

  // one write port: literals in idle, landed copy bytes during a run
  assign wr_pos    = cmd.accept ? eff_count : count_r;
  assign mem_we    = ((cmd.accept && kind == KIND_LIT) || rd_pending_r) &&
                     ({1'b0, wr_pos} < DEPTH_W);
  assign mem_waddr = wr_pos[AW-1:0];
  assign mem_wdata = cmd.accept ? in_data.in_byte : land_byte;
  assign mem_re    = cmd.issue_rd && rpos_in_range;

  always_comb begin
    pack_ins = pack_data_r;
    for (int i = 0; i < BYTES_PER_RESULT; i++) begin
      if (pack_cnt_r == CW'(i)) begin
        pack_ins[8*i +: 8] = land_byte;
      end
    end
  end

  // write-first read so an overlapping copy sees the byte landed this cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      if (mem_we && mem_waddr == rpos_r[AW-1:0]) begin
        rd_data_r <= mem_wdata;
      end else begin
        rd_data_r <= mem[rpos_r[AW-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= 5'd0;
      count_r      <= 16'd0;
      remain_r     <= 9'd0;
      rd_pending_r <= 1'b0;
      pack_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      rd_pending_r <= cmd.issue_rd;
      if (cmd.accept) begin
        phase_r <= phase_nxt;
        if (kind == KIND_LIT) begin
          count_r <= (eff_count == COUNT_MAX) ? eff_count : eff_count + 16'd1;
        end else begin
          count_r <= eff_count;
        end
        if (kind == KIND_COPY) begin
          remain_r   <= 9'(len_r) + MIN_MATCH;
          pack_cnt_r <= '0;
        end
      end
      if (cmd.issue_rd) begin
        remain_r <= remain_r - 9'd1;
      end
      if (rd_pending_r) begin
        count_r    <= (count_r == COUNT_MAX) ? count_r : count_r + 16'd1;
        pack_cnt_r <= pack_cnt_r + CW'(1);
      end
      if (cmd.flush) begin
        pack_cnt_r <= '0;
      end
      if ((cmd.accept && (kind == KIND_LIT || kind == KIND_BAD)) || cmd.flush) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      off_r <= off_nxt;
      len_r <= len_nxt;
      if (kind == KIND_COPY) begin
        rpos_r      <= {1'b0, off_r};
        pack_data_r <= '0;
      end
      if (kind == KIND_LIT) begin
        out_r.out_bytes     <= 64'(in_data.in_byte);
        out_r.byte_count    <= 4'd1;
        out_r.last_of_run   <= 1'b1;
        out_r.bad_reference <= 1'b0;
      end else if (kind == KIND_BAD) begin
        out_r.out_bytes     <= 64'd0;
        out_r.byte_count    <= 4'd0;
        out_r.last_of_run   <= 1'b1;
        out_r.bad_reference <= 1'b1;
      end
    end
    if (cmd.issue_rd) begin
      rpos_r    <= rpos_r + 16'd1;
      rd_zero_r <= !rpos_in_range;
    end
    if (rd_pending_r) begin
      pack_data_r <= pack_ins;
    end
    if (cmd.flush) begin
      out_r.out_bytes     <= 64'(pack_data_r);
      out_r.byte_count    <= 4'(pack_cnt_r);
      out_r.last_of_run   <= (remain_r == 9'd0);
      out_r.bad_reference <= 1'b0;
      pack_data_r         <= '0;
    end
  end

  always_comb begin
    status.kind       = kind;
    status.remain_nz  = (remain_r != 9'd0);
    status.pack_room  = ((CW + 1)'(pack_cnt_r) + (CW + 1)'(rd_pending_r)) < BPR_W;
    status.pack_full  = ((CW + 1)'(pack_cnt_r) == BPR_W);
    status.pack_nz    = (pack_cnt_r != '0);
    status.rd_pending = rd_pending_r;
    status.out_free   = out_free;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[src/lz77_token_stream_decoder.sv]
// LZ77 token stream decoder. Token and literal bytes: one per cycle while the
// output is free and no copy runs; a literal or error result is in the output
// register in the cycle after its request. A copy of n bytes holds the input
// and reads the history RAM one byte per cycle while the packer has room; a
// packed result is flushed after its last read lands. Synchronous reset clears
// parse state, output count and handshake state; history undefined.
module lz77_token_stream_decoder #(
  parameter int HISTORY_DEPTH    = 32768,
  parameter int BYTES_PER_RESULT = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lztd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lztd_pkg::out_item_t out_data
);
  import lztd_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  lztd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  lztd_datapath #(
    .HISTORY_DEPTH    (HISTORY_DEPTH),
    .BYTES_PER_RESULT (BYTES_PER_RESULT)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[sim/lztd_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the LZ77 token stream decoder: follows the token parse and the
// output history, predicts the results of each accepted request and compares.
// Depends on lztd_pkg.
module lztd_checker #(
  parameter int HISTORY_DEPTH    = 32768,
  parameter int BYTES_PER_RESULT = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  lztd_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  lztd_pkg::out_item_t out_data,
  output int                  errors,
  output int                  pending,
  output int                  checked,
  output logic [15:0]         produced
);
  import lztd_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);

  logic [4:0]  tok_phase;
  logic [14:0] off_acc;
  logic [7:0]  len_acc;
  logic [7:0]  hist_mem [HISTORY_DEPTH];
  out_item_t   expected_q [$];

  task automatic append_byte(input logic [7:0] b);
    if (produced < HISTORY_DEPTH) hist_mem[produced[AW-1:0]] = b;
    if (produced != COUNT_MAX) produced = produced + 16'd1;
  endtask

  task automatic decode_request(input in_item_t req);
    out_item_t  res;
    logic       one;
    int         n;
    int         pos;
    int         slot;
    logic [7:0] v;
    if (req.start_of_stream) begin
      tok_phase = '0;
      off_acc   = '0;
      len_acc   = '0;
      produced  = '0;
    end
    if (tok_phase == '0) begin
      if (req.in_byte == TOKEN_OPEN) begin
        tok_phase = 5'd1;
        off_acc   = '0;
        len_acc   = '0;
      end else begin
        append_byte(req.in_byte);
        res = '0;
        res.out_bytes[7:0] = req.in_byte;
        res.byte_count     = 4'd1;
        res.last_of_run    = 1'b1;
        expected_q.push_back(res);
      end
    end else begin
      one = (req.in_byte == BIT_ONE);
      if (tok_phase <= OFFSET_LAST) off_acc = {off_acc[13:0], one};
      else if (tok_phase >= LENGTH_FIRST && tok_phase <= LENGTH_LAST)
        len_acc = {len_acc[6:0], one};
      if (tok_phase < TOKEN_LAST) begin
        tok_phase = tok_phase + 5'd1;
      end else begin
        tok_phase = '0;
        res = '0;
        if (off_acc >= produced) begin
          res.last_of_run   = 1'b1;
          res.bad_reference = 1'b1;
          expected_q.push_back(res);
        end else begin
          n = int'(len_acc) + int'(MIN_MATCH);
          // byte-wise copy: later reads may hit bytes this copy just wrote
          for (int k = 0; k < n; k++) begin
            pos = int'(off_acc) + k;
            v = (pos < HISTORY_DEPTH) ? hist_mem[pos[AW-1:0]] : 8'h00;
            append_byte(v);
            slot = k % BYTES_PER_RESULT;
            if (slot == 0 && k != 0) begin
              expected_q.push_back(res);
              res = '0;
            end
            res.out_bytes[8*slot +: 8] = v;
            res.byte_count = res.byte_count + 4'd1;
          end
          res.last_of_run = 1'b1;
          expected_q.push_back(res);
        end
      end
    end
  endtask

  task automatic report_field(input string fname, input logic [63:0] want,
                              input logic [63:0] got);
    $display("%0t: %s expected %h got %h", $time, fname, want, got);
    errors++;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: result with none expected: %h", $time, got);
      errors++;
    end else begin
      want = expected_q.pop_front();
      checked++;
      if (got.out_bytes !== want.out_bytes)
        report_field("out_bytes", want.out_bytes, got.out_bytes);
      if (got.byte_count !== want.byte_count)
        report_field("byte_count", 64'(want.byte_count), 64'(got.byte_count));
      if (got.last_of_run !== want.last_of_run)
        report_field("last_of_run", 64'(want.last_of_run), 64'(got.last_of_run));
      if (got.bad_reference !== want.bad_reference)
        report_field("bad_reference", 64'(want.bad_reference),
                     64'(got.bad_reference));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tok_phase = '0;
      off_acc   = '0;
      len_acc   = '0;
      produced  = '0;
      errors    = 0;
      checked   = 0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (in_valid && !in_stall) decode_request(in_data);
    end
    pending = expected_q.size();
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for the LZ77 token stream decoder: clock, reset, request
// stimulus with random gaps, output stalls, watchdog and verdict.
// Depends on lztd_pkg, lztd_checker and lz77_token_stream_decoder.
module tb_top;
  import lztd_pkg::*;

  localparam int HIST_DEPTH = 32768;
  localparam int PACK_BYTES = 8;
  localparam int IDLE_LIMIT = 3000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  int          errors;
  int          pending;
  int          checked;
  logic [15:0] produced;

  bit calm        = 1'b0;
  int requests    = 0;
  int streams     = 0;
  int tokens      = 0;
  int idle_cycles = 0;
  int stall_left  = 0;

  always #1 clk = ~clk;

  lz77_token_stream_decoder #(
    .HISTORY_DEPTH   (HIST_DEPTH),
    .BYTES_PER_RESULT(PACK_BYTES)
  ) dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
  );

  lztd_checker #(
    .HISTORY_DEPTH   (HIST_DEPTH),
    .BYTES_PER_RESULT(PACK_BYTES)
  ) u_check (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .errors, .pending, .checked, .produced
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] rand_literal();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == TOKEN_OPEN);
    return c;
  endfunction

  // any byte but '1' counts as a zero bit
  function automatic logic [7:0] zero_char(input bit ff_fill);
    logic [7:0] c;
    if (ff_fill) return TOKEN_OPEN;
    do c = 8'($urandom_range(0, 255)); while (c == BIT_ONE);
    return c;
  endfunction

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top: watchdog, no handshake for %0d cycles", IDLE_LIMIT);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) stall_left = stall_left - 1;
    else if (!calm) stall_left = gap_len();
    out_stall <= (stall_left > 0) && !calm;
  end

  // entered and left at a falling edge; valid stays up until the next call
  task automatic send_item(input logic sos, input logic [7:0] b);
    int gap;
    gap = calm ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{start_of_stream: sos, in_byte: b};
    do begin
      @(posedge clk);
    end while (in_stall);
    @(negedge clk);
    requests++;
    if (sos) streams++;
  endtask

  task automatic send_token(input logic sos, input logic [14:0] off,
                            input logic [7:0] len, input bit ff_fill);
    send_item(sos, TOKEN_OPEN);
    for (int i = 14; i >= 0; i--) send_item(1'b0, off[i] ? BIT_ONE : zero_char(ff_fill));
    send_item(1'b0, 8'($urandom_range(0, 255)));
    for (int i = 7; i >= 0; i--) send_item(1'b0, len[i] ? BIT_ONE : zero_char(ff_fill));
    send_item(1'b0, 8'($urandom_range(0, 255)));
    tokens++;
  endtask

  // token dropped by a new stream after its opening byte and n more bytes
  task automatic cut_token(input int n);
    send_item(1'b0, TOKEN_OPEN);
    repeat (n) send_item(1'b0, 8'($urandom_range(0, 255)));
    send_item(1'b1, rand_literal());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int prod;
    int off;
    int len;
    int r;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed
    send_item(1'b1, 8'h00);
    send_item(1'b0, 8'hFE);
    send_item(1'b0, BIT_ONE);
    send_item(1'b0, 8'h7F);
    send_token(1'b0, 15'd0, 8'd0, 1'b0);
    send_token(1'b0, 15'd6, 8'd12, 1'b1);   // overlapping copy, last byte repeats
    send_token(1'b0, 15'd0, 8'd255, 1'b0);  // longest copy
    send_token(1'b0, 15'h7FFF, 8'hFF, 1'b0);
    send_token(1'b0, produced[14:0], 8'd1, 1'b0);  // offset equal to count
    cut_token(5);
    send_token(1'b1, 15'd0, 8'd0, 1'b0);    // new stream inside opening byte
    drain();

    // random
    send_item(1'b1, rand_literal());
    while (requests < 380) begin
      if ($urandom_range(0, 19) == 0) calm = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 29) == 0) drain();
      r = $urandom_range(0, 99);
      prod = int'(produced);
      if (r < 40 || (r < 75 && prod == 0)) begin
        send_item($urandom_range(0, 29) == 0, rand_literal());
      end else if (r < 75) begin
        if ($urandom_range(0, 1)) off = prod - 1 - $urandom_range(0, (prod > 8) ? 8 : prod - 1);
        else off = $urandom_range(0, (prod > 32768) ? 32767 : prod - 1);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 255) : $urandom_range(0, 20);
        send_token(1'b0, off[14:0], len[7:0], $urandom_range(0, 7) == 0);
      end else if (r < 85) begin
        len = $urandom_range(0, 255);
        if ($urandom_range(0, 3) == 0) begin
          off = $urandom_range(0, 32767);
          send_token(1'b1, off[14:0], len[7:0], 1'b0);
        end else if (prod <= 32767) begin
          off = $urandom_range(0, 1) ? prod : $urandom_range(prod, 32767);
          send_token(1'b0, off[14:0], len[7:0], 1'b0);
        end
      end else if (r < 92) begin
        cut_token($urandom_range(0, 24));
      end else begin
        send_item($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)));
      end
    end
    calm = 1'b0;

    drain();
    repeat (20) @(negedge clk);
    $display("tb_top: %0d requests in %0d streams, %0d tokens, %0d results checked",
             requests, streams, tokens, checked);
    $display("tb_top: literals, short and long copies, overlapping and bad copies, cut tokens");
    if (errors == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
src/lztd_pkg.sv
src/lztd_ctrl.sv
src/lztd_datapath.sv
src/lz77_token_stream_decoder.sv
sim/lztd_checker.sv
sim/tb_top.sv
